>>> src/rfc_pkg.sv
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types, constants and the byte-wide CRC-16 update for the reply
// frame checker.
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam int          CRC_TOP   = 15;

    localparam int          BYTE_W    = 8;
    localparam int          VALUE_W   = 32;
    localparam int          POS_W     = 3;

    // Byte positions inside a reply
    localparam logic [POS_W-1:0] POS_DIR   = 3'd4;
    localparam logic [POS_W-1:0] POS_HI_ND = 3'd4;
    localparam logic [POS_W-1:0] POS_HI_D  = 3'd5;

    // Item kind carried in tuser
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_BYTE  = 1'b1;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    typedef struct packed {
        logic              func;
        logic [BYTE_W-1:0] command_code;
        logic              with_direction;
        logic [BYTE_W-1:0] rx_byte;
    } rfc_item_t;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] reading;
        logic               crc_ok;
    } rfc_result_t;

    // CRC-16, MSB first: one byte, eight shift steps
    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc,
                                                 input logic [BYTE_W-1:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[CRC_TOP])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> src/reply_frame_checker_top.sv
// ----------------------------------------------------------------------------
// reply_frame_checker_top
// Checks a controller reply to a 32-bit reading request: rebuilds the
// CRC-16, assembles the signed reading and reports whether the CRC matched.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake         | payload
//  ----------+-----------+-------------------+------------------------------
//  s_*       | in        | s_tvalid/s_tready | tuser: func; tdata: command,
//            |           |                   |   with_direction, rx_byte
//  m_*       | out       | m_tvalid/m_tready | tdata: reading, crc_ok
//  cfg_*     | in        | cfg_wr_en         | device address byte
//
//  One transfer per cycle sustained while no held result stalls. Each
//  transfer lands in an input register, then the CRC/assembly logic
//  updates the frame state and, on the last CRC byte, loads the result
//  register. A held result stalls only an item that itself completes a
//  frame; all other items keep flowing. rst_n clears the frame state,
//  closes any open request and sets the device address to zero.
//
module reply_frame_checker_top
    import rfc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration: device address
    input  logic                   cfg_wr_en,
    input  logic [BYTE_W-1:0]      cfg_wr_data,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] command_code, [8] with_direction,
                                              // [16:9] rx_byte, [23:17] zero
    input  logic [0:0]             s_tuser,   // [0] func
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [31:0] reading, [32] crc_ok, [39:33] zero
);

    rfc_item_t   in_item;
    rfc_item_t   item;
    logic        item_valid;
    logic        item_take;
    rfc_result_t result;

    // Unpack the slave payload
    assign in_item.func           = s_tuser[0];
    assign in_item.command_code   = s_tdata[7:0];
    assign in_item.with_direction = s_tdata[8];
    assign in_item.rx_byte        = s_tdata[16:9];

    rfc_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    rfc_frame_core u_frame_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take),
        .result      (result),
        .result_take (m_tready)
    );

    // Pack the master payload, zero fill to whole bytes
    assign m_tvalid = result.valid;
    assign m_tdata  = {7'd0, result.crc_ok, result.reading};

endmodule

>>> src/rfc_in_stage.sv
// ----------------------------------------------------------------------------
// rfc_in_stage
// Input register: captures one transfer and holds it until the core takes it.
// ----------------------------------------------------------------------------
module rfc_in_stage
    import rfc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  rfc_item_t in_item,
    output logic      item_valid,
    output rfc_item_t item,
    input  logic      item_take
);

    logic      valid_reg;
    logic      valid_next;
    rfc_item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (item_take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_item;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> src/rfc_frame_core.sv
// ----------------------------------------------------------------------------
// rfc_frame_core
// Frame state, CRC accumulation and the result register.
// ----------------------------------------------------------------------------
module rfc_frame_core
    import rfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [BYTE_W-1:0] cfg_wr_data,
    input  logic              item_valid,
    input  rfc_item_t         item,
    output logic              item_take,
    output rfc_result_t       result,
    input  logic              result_take
);

    logic [BYTE_W-1:0]  addr_reg;
    logic [15:0]        crc_reg,   crc_next;
    logic [POS_W-1:0]   pos_reg,   pos_next;
    logic [VALUE_W-1:0] acc_reg,   acc_next;
    logic               dir_reg,   dir_next;
    logic               open_reg,  open_next;
    logic [BYTE_W-1:0]  hi_reg,    hi_next;
    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] reading_reg;
    logic               crc_ok_reg;

    logic               fire;
    logic [POS_W-1:0]   hi_pos;

    assign hi_pos = dir_reg ? POS_HI_D : POS_HI_ND;

    always_comb
    begin
        crc_next  = crc_reg;
        pos_next  = pos_reg;
        acc_next  = acc_reg;
        dir_next  = dir_reg;
        open_next = open_reg;
        hi_next   = hi_reg;
        fire      = 1'b0;
        if (item.func == FUNC_START)
        begin
            crc_next  = crc_add_byte(crc_add_byte(16'h0000, addr_reg), item.command_code);
            pos_next  = '0;
            acc_next  = '0;
            dir_next  = item.with_direction;
            hi_next   = '0;
            open_next = 1'b1;
        end
        else if (open_reg)
        begin
            if (pos_reg < POS_DIR)
            begin
                crc_next = crc_add_byte(crc_reg, item.rx_byte);
                acc_next = {acc_reg[VALUE_W-BYTE_W-1:0], item.rx_byte};
                pos_next = pos_reg + 3'd1;
            end
            else if (dir_reg && pos_reg == POS_DIR)
            begin
                crc_next = crc_add_byte(crc_reg, item.rx_byte);
                if (item.rx_byte != '0)
                    acc_next = VALUE_W'(-acc_reg);
                pos_next = pos_reg + 3'd1;
            end
            else if (pos_reg == hi_pos)
            begin
                hi_next  = item.rx_byte;
                pos_next = pos_reg + 3'd1;
            end
            else
            begin
                fire      = 1'b1;
                open_next = 1'b0;
                pos_next  = '0;
            end
        end
    end

    // Stall only an item that would overwrite a result not yet taken
    assign item_take      = item_valid && !(fire && out_valid_reg && !result_take);
    assign out_valid_next = (item_take && fire) ? 1'b1
                          : (result_take ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            crc_reg       <= '0;
            pos_reg       <= '0;
            acc_reg       <= '0;
            dir_reg       <= 1'b0;
            open_reg      <= 1'b0;
            hi_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                addr_reg <= cfg_wr_data;
            if (item_take)
            begin
                crc_reg  <= crc_next;
                pos_reg  <= pos_next;
                acc_reg  <= acc_next;
                dir_reg  <= dir_next;
                open_reg <= open_next;
                hi_reg   <= hi_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take && fire)
        begin
            reading_reg <= acc_reg;
            crc_ok_reg  <= ({hi_reg, item.rx_byte} == crc_reg);
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.reading = reading_reg;
    assign result.crc_ok  = crc_ok_reg;

endmodule
